>>> hdl/est_pkg.sv
// ============================================================================
// Event statistics table: shared definitions
// Field widths, payload structs, the table entry, register indexes, operation
// codes and the sequencer states used by the statistics table and its units.
// ============================================================================
package est_pkg;

   // Number of statistics entries and the table address width.
   localparam int NUM_EVENTS = 16;
   localparam int EV_AW      = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

   // Index compare width: wide enough to hold the entry count.
   localparam int IDX_CMP_W = 9;
   localparam logic [IDX_CMP_W-1:0] EVENT_LIMIT = IDX_CMP_W'(NUM_EVENTS);

   // Datapath widths.
   localparam int STAMP_W    = 48;
   localparam int DUR_W      = 32;
   localparam int STAT_W     = 64;
   localparam int DIVISOR_W  = 42;
   localparam int DIV_CNT_W  = $clog2(STAT_W);
   localparam logic [DUR_W-1:0] DUR_MAX = '1;

   // Throughput is reported in thousands of bytes per second.
   localparam int KILO = 1000;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS  = 4'd1;
   localparam logic [31:0] TICKS_RESET = 32'd1000000000;

   // Operation codes.
   localparam logic OP_DURATION   = 1'b0;
   localparam logic OP_THROUGHPUT = 1'b1;

   typedef struct packed {
      logic               op;
      logic [3:0]         event_index;
      logic [STAMP_W-1:0] begin_stamp;
      logic [STAMP_W-1:0] end_stamp;
      logic [31:0]        byte_count;
   } req_item_type;

   typedef struct packed {
      logic              recorded;
      logic [31:0]       count_out;
      logic [STAT_W-1:0] sum_out;
      logic [STAT_W-1:0] sum_squares_out;
      logic [STAT_W-1:0] minimum_out;
      logic [STAT_W-1:0] maximum_out;
      logic [STAT_W-1:0] total_bytes_out;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0]       count;
      logic [STAT_W-1:0] sum;
      logic [STAT_W-1:0] sqsum;
      logic [STAT_W-1:0] minimum;
      logic [STAT_W-1:0] maximum;
      logic [STAT_W-1:0] byte_total;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic [EV_AW-1:0] addr;
   } tbl_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DURATION,
      ST_PRODUCT,
      ST_DIVIDE,
      ST_SQUARE,
      ST_SUM,
      ST_SQSUM,
      ST_BYTES,
      ST_RESPOND
   } state_type;

endpackage

>>> hdl/est_divider.sv
// ============================================================================
// Event statistics table: serial divider
// Restoring divider that produces one quotient bit per cycle, shifting the
// dividend out of the quotient register as the quotient bits shift in.
// ============================================================================
module est_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [est_pkg::STAT_W-1:0]       dividend,
   input  logic [est_pkg::DIVISOR_W-1:0]    divisor,
   output logic                             done,
   output logic [est_pkg::STAT_W-1:0]       quotient
);

   logic                            busy_ff;
   logic                            busy_in;
   logic                            done_ff;
   logic                            done_in;
   logic [est_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [est_pkg::DIV_CNT_W-1:0]   cnt_in;
   logic [est_pkg::DIVISOR_W-1:0]   rem_ff;
   logic [est_pkg::DIVISOR_W-1:0]   rem_in;
   logic [est_pkg::DIVISOR_W-1:0]   dsr_ff;
   logic [est_pkg::DIVISOR_W-1:0]   dsr_in;
   logic [est_pkg::STAT_W-1:0]      quo_ff;
   logic [est_pkg::STAT_W-1:0]      quo_in;
   logic [est_pkg::DIVISOR_W:0]     trial;
   logic [est_pkg::DIVISOR_W+1:0]   diff;

   // The partial remainder stays below the divisor, so one trial subtract
   // per cycle decides the next quotient bit.
   assign trial = {rem_ff, quo_ff[est_pkg::STAT_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (diff[est_pkg::DIVISOR_W+1]) begin
            rem_in = trial[est_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[est_pkg::STAT_W-2:0], 1'b0};
         end else begin
            rem_in = diff[est_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[est_pkg::STAT_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + est_pkg::DIV_CNT_W'(1);
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/est_table.sv
// ============================================================================
// Event statistics table: entry memory
// One statistics entry per event with a registered read port, a write port
// and a valid bit per entry so that unwritten entries read as zero.
// ============================================================================
module est_table (
   input  logic                 clock,
   input  logic                 reset,
   input  est_pkg::tbl_ctl_type ctl,
   input  est_pkg::entry_type   wr_data,
   output est_pkg::entry_type   rd_data
);

   est_pkg::entry_type             mem [est_pkg::NUM_EVENTS];
   logic [est_pkg::NUM_EVENTS-1:0] valid_ff;
   logic                           rd_valid_ff;
   est_pkg::entry_type             rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[ctl.addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[ctl.addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> hdl/event_statistics_table_unit.sv
// ============================================================================
// Event statistics table
// Keeps count, sum, sum of squares, minimum, maximum and byte total for each
// event and reports the updated entry for every recorded event.
// ============================================================================
// A request transfer happens at a clock edge with start high and busy low.
// It names an event entry, the begin and end stamps and a byte count. The
// block answers every request with exactly one result, shown on rsp_item for
// a single cycle with rsp_valid high; the receiver cannot stall it.
// Duration requests step through the duration, product, square, sum, sum of
// squares and bytes states to the result. Throughput requests also wait in
// the divide state for a bit-serial divider that retires one quotient bit
// per cycle over a 64-bit dividend. Ignored requests (block disabled, entry
// out of range, or a zero duration in throughput mode) answer with zeros after
// the duration or product state. One request is worked on at a time; busy
// falls the cycle after the result, so the next request may be taken then.
// Configuration writes use csr_valid and csr_ready (always ready); index 0 is
// enable and index 1 is ticks per second. The user must make writes only
// while idle; the block does not enforce it. Reset is synchronous: it
// disables recording, restores ticks per second to one billion and clears
// the valid bit of every table entry, so no clearing pass is needed.
// ============================================================================
module event_statistics_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  est_pkg::req_item_type               req_item,
   output logic                                rsp_valid,
   output est_pkg::rsp_item_type               rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [est_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_data
);

   localparam int SW = est_pkg::STAT_W;

   // Saturating 64-bit add: the carry out selects the all-ones value.
   function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a,
                                              input logic [SW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SW] ? '1 : s[SW-1:0];
   endfunction

   // Control state.
   est_pkg::state_type state_ff;
   est_pkg::state_type state_in;
   logic               enable_ff;
   logic [31:0]        tps_ff;

   // Working registers for the item in flight.
   est_pkg::req_item_type          item_ff;
   est_pkg::req_item_type          item_in;
   logic [est_pkg::DUR_W-1:0]      dur_ff;
   logic [est_pkg::DUR_W-1:0]      dur_in;
   logic [SW-1:0]                  sample_ff;
   logic [SW-1:0]                  sample_in;
   logic [SW-1:0]                  square_ff;
   logic [SW-1:0]                  square_in;
   logic                           recorded_ff;
   logic                           recorded_in;
   est_pkg::entry_type             upd_ff;
   est_pkg::entry_type             upd_in;

   // Table and divider hookup.
   est_pkg::tbl_ctl_type           tbl_ctl;
   est_pkg::entry_type             entry;
   logic                           div_start;
   logic                           div_done;
   logic [SW-1:0]                  div_quotient;
   logic [SW-1:0]                  product;
   logic [est_pkg::DIVISOR_W-1:0]  divisor;

   logic [est_pkg::STAMP_W:0]      stamp_diff;
   logic                           in_range;
   logic                           first;

   assign stamp_diff = {1'b0, item_ff.end_stamp} - {1'b0, item_ff.begin_stamp};
   assign in_range   = est_pkg::IDX_CMP_W'(item_ff.event_index) < est_pkg::EVENT_LIMIT;
   assign first      = (entry.count == '0);

   // Dividing by kilo and then by the duration floors the same as dividing
   // once by kilo times the duration, so one divide pass is enough.
   assign product = SW'(tps_ff) * SW'(item_ff.byte_count);
   assign divisor = est_pkg::DIVISOR_W'(dur_ff) * est_pkg::DIVISOR_W'(est_pkg::KILO);

   est_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   est_table u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tbl_ctl),
      .wr_data (upd_ff),
      .rd_data (entry)
   );

   // Sequencer: next state, datapath updates and handshake outputs.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      dur_in       = dur_ff;
      sample_in    = sample_ff;
      square_in    = square_ff;
      recorded_in  = recorded_ff;
      upd_in       = upd_ff;
      div_start    = 1'b0;
      tbl_ctl.rd_en = 1'b0;
      tbl_ctl.wr_en = 1'b0;
      tbl_ctl.addr  = est_pkg::EV_AW'(item_ff.event_index);
      case (state_ff)
         est_pkg::ST_IDLE: begin
            if (start) begin
               item_in     = req_item;
               recorded_in = 1'b0;
               state_in    = est_pkg::ST_DURATION;
            end
         end
         est_pkg::ST_DURATION: begin
            // End before begin gives zero; long events clip at 32 bits.
            if (stamp_diff[est_pkg::STAMP_W]) begin
               dur_in = '0;
            end else if (stamp_diff[est_pkg::STAMP_W-1:est_pkg::DUR_W] != '0) begin
               dur_in = est_pkg::DUR_MAX;
            end else begin
               dur_in = stamp_diff[est_pkg::DUR_W-1:0];
            end
            tbl_ctl.rd_en = 1'b1;
            if (!enable_ff || !in_range) begin
               state_in = est_pkg::ST_RESPOND;
            end else begin
               state_in = est_pkg::ST_PRODUCT;
            end
         end
         est_pkg::ST_PRODUCT: begin
            if (item_ff.op == est_pkg::OP_DURATION) begin
               sample_in = SW'(dur_ff);
               state_in  = est_pkg::ST_SQUARE;
            end else if (dur_ff == '0) begin
               state_in = est_pkg::ST_RESPOND;
            end else begin
               div_start = 1'b1;
               state_in  = est_pkg::ST_DIVIDE;
            end
         end
         est_pkg::ST_DIVIDE: begin
            if (div_done) begin
               sample_in = div_quotient;
               state_in  = est_pkg::ST_SQUARE;
            end
         end
         est_pkg::ST_SQUARE: begin
            if (sample_ff[SW-1:32] != '0) begin
               square_in = '1;
            end else begin
               square_in = SW'(sample_ff[31:0]) * SW'(sample_ff[31:0]);
            end
            recorded_in = 1'b1;
            state_in    = est_pkg::ST_SUM;
         end
         est_pkg::ST_SUM: begin
            upd_in.sum = sat_add(entry.sum, sample_ff);
            if (first || (sample_ff < entry.minimum)) begin
               upd_in.minimum = sample_ff;
            end else begin
               upd_in.minimum = entry.minimum;
            end
            state_in = est_pkg::ST_SQSUM;
         end
         est_pkg::ST_SQSUM: begin
            upd_in.sqsum = sat_add(entry.sqsum, square_ff);
            if (first || (sample_ff > entry.maximum)) begin
               upd_in.maximum = sample_ff;
            end else begin
               upd_in.maximum = entry.maximum;
            end
            state_in = est_pkg::ST_BYTES;
         end
         est_pkg::ST_BYTES: begin
            if (item_ff.op == est_pkg::OP_THROUGHPUT) begin
               upd_in.byte_total = sat_add(entry.byte_total, SW'(item_ff.byte_count));
            end else begin
               upd_in.byte_total = entry.byte_total;
            end
            if (entry.count == '1) begin
               upd_in.count = entry.count;
            end else begin
               upd_in.count = entry.count + 32'd1;
            end
            state_in = est_pkg::ST_RESPOND;
         end
         est_pkg::ST_RESPOND: begin
            tbl_ctl.wr_en = recorded_ff;
            state_in      = est_pkg::ST_IDLE;
         end
         default: begin
            state_in = est_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= est_pkg::ST_IDLE;
         recorded_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         recorded_ff <= recorded_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      dur_ff    <= dur_in;
      sample_ff <= sample_in;
      square_ff <= square_in;
      upd_ff    <= upd_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         tps_ff    <= est_pkg::TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            est_pkg::CSR_ENABLE: enable_ff <= csr_data[0];
            est_pkg::CSR_TICKS:  tps_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != est_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == est_pkg::ST_RESPOND);

   // An ignored request reports all zeros.
   always_comb begin
      rsp_item = '0;
      if (recorded_ff) begin
         rsp_item.recorded        = 1'b1;
         rsp_item.count_out       = upd_ff.count;
         rsp_item.sum_out         = upd_ff.sum;
         rsp_item.sum_squares_out = upd_ff.sqsum;
         rsp_item.minimum_out     = upd_ff.minimum;
         rsp_item.maximum_out     = upd_ff.maximum;
         rsp_item.total_bytes_out = upd_ff.byte_total;
      end
   end

   // A request transfer always starts work.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not start work");

   // After a result the block is ready for the next request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after result");

   // A recorded result never shows an empty entry.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.recorded) |-> (rsp_item.count_out != '0))
      else $error("recorded result with zero count");

   // The minimum of an entry never exceeds its maximum.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.recorded) |-> (rsp_item.minimum_out <= rsp_item.maximum_out))
      else $error("entry minimum above maximum");

   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == est_pkg::ST_DIVIDE))
      else $error("divider finished outside the divide phase");

endmodule

>>> tb/event_statistics_table_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Event statistics table testbench
// Drives finished-event requests into the statistics table and checks every
// result against a cycle-free shadow of the table that this bench keeps.
// Directed cases cover the duration and throughput corner cases, the clock
// rate extremes and the disabled state; a sum-of-squares saturation check and
// randomized traffic with varied sender idling follow.
// ============================================================================
module event_statistics_table_unit_tb;

   // The run is far shorter than this; it only catches a hung block.
   localparam int TIMEOUT_NS     = 4_000_000;
   localparam int RANDOM_PHASE_N = 240;
   localparam int SATURATE_N     = 4;
   localparam int SETTLE_CYCLES  = 100;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   est_pkg::req_item_type           req_item;
   logic                            rsp_valid;
   est_pkg::rsp_item_type           rsp_item;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [est_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [31:0]                     csr_data;

   // Shadow copy of the table and of the two registers, updated as each
   // request transfer is taken and each register write completes.
   est_pkg::entry_type              stat_shadow [est_pkg::NUM_EVENTS];
   logic                            record_enable;
   logic [31:0]                     tick_rate;

   // Updated entries that the block still owes, oldest first.
   est_pkg::rsp_item_type           expected_stats [$];
   int                              error_count;

   event_statistics_table_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Unsigned add that sticks at all ones instead of wrapping.
   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[64] ? '1 : total[63:0];
   endfunction

   // Works out the sample for one request, folds it into the shadow entry
   // and returns the result the block should report. Ignored requests give
   // an all-zero result and leave the shadow untouched.
   function automatic est_pkg::rsp_item_type update_statistics(est_pkg::req_item_type ev);
      est_pkg::rsp_item_type result;
      est_pkg::entry_type    entry;
      logic [63:0]           span;
      logic [63:0]           sample;
      logic [63:0]           product;
      logic [63:0]           square;
      result = '0;
      if (!record_enable || int'(ev.event_index) >= est_pkg::NUM_EVENTS)
         return result;

      // Duration in ticks: negative spans count as zero, long ones clip.
      span = (ev.end_stamp >= ev.begin_stamp) ?
             64'(ev.end_stamp - ev.begin_stamp) : 64'd0;
      if (span > 64'(est_pkg::DUR_MAX))
         span = 64'(est_pkg::DUR_MAX);

      if (ev.op == est_pkg::OP_THROUGHPUT) begin
         // A zero duration has no meaningful rate, so it is dropped.
         if (span == 0)
            return result;
         product = 64'(tick_rate) * 64'(ev.byte_count);
         sample  = product / 64'(est_pkg::KILO) / span;
      end else begin
         sample = span;
      end

      entry = stat_shadow[ev.event_index];
      // The first sample of an empty entry defines both bounds.
      if (entry.count == 0) begin
         entry.minimum = sample;
         entry.maximum = sample;
      end
      if (sample < entry.minimum)
         entry.minimum = sample;
      if (sample > entry.maximum)
         entry.maximum = sample;
      square      = (sample > 64'(est_pkg::DUR_MAX)) ? '1 : sample * sample;
      entry.sum   = sat_add(entry.sum, sample);
      entry.sqsum = sat_add(entry.sqsum, square);
      if (ev.op == est_pkg::OP_THROUGHPUT)
         entry.byte_total = sat_add(entry.byte_total, 64'(ev.byte_count));
      if (entry.count != '1)
         entry.count = entry.count + 1;
      stat_shadow[ev.event_index] = entry;

      result.recorded        = 1'b1;
      result.count_out       = entry.count;
      result.sum_out         = entry.sum;
      result.sum_squares_out = entry.sqsum;
      result.minimum_out     = entry.minimum;
      result.maximum_out     = entry.maximum;
      result.total_bytes_out = entry.byte_total;
      return result;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s mismatch: expected %0h, actual %0h",
                  $time, field, want, got);
      end
   endtask

   // Results last one cycle and cannot be held off, so every rising edge
   // with the strobe high is a result transfer that must match the oldest
   // expectation.
   always @(posedge clock) begin
      est_pkg::rsp_item_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_stats.size() == 0) begin
            error_count++;
            $display("%0t ns: result with none expected: expected none, actual %h",
                     $time, rsp_item);
         end else begin
            want = expected_stats.pop_front();
            report_field("recorded", 64'(want.recorded), 64'(rsp_item.recorded));
            report_field("count_out", 64'(want.count_out), 64'(rsp_item.count_out));
            report_field("sum_out", want.sum_out, rsp_item.sum_out);
            report_field("sum_squares_out", want.sum_squares_out,
                         rsp_item.sum_squares_out);
            report_field("minimum_out", want.minimum_out, rsp_item.minimum_out);
            report_field("maximum_out", want.maximum_out, rsp_item.maximum_out);
            report_field("total_bytes_out", want.total_bytes_out,
                         rsp_item.total_bytes_out);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Presents one request from the falling edge and holds it until the block
   // takes it. Start is left high on return, so a request that follows right
   // away keeps start high with no dip; whoever pauses lowers it first.
   task automatic issue_event(input est_pkg::req_item_type ev);
      @(negedge clock);
      start    = 1'b1;
      req_item = ev;
      do @(posedge clock); while (busy);
      expected_stats.push_back(update_statistics(ev));
   endtask

   // Keeps the request side quiet for a number of cycles.
   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Stops sending and waits until every owed result has arrived and the
   // block reports itself free. Each request gets exactly one result, so
   // nothing can still be in flight once this returns.
   task automatic wait_for_idle();
      @(negedge clock);
      start = 1'b0;
      while (expected_stats.size() != 0)
         @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // One register write transfer; the shadow copy follows the write.
   task automatic write_register(input logic [est_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      if (index == est_pkg::CSR_ENABLE)
         record_enable = value[0];
      else if (index == est_pkg::CSR_TICKS)
         tick_rate = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic est_pkg::req_item_type make_event(logic op, int unsigned index,
                                                        logic [47:0] begin_at,
                                                        logic [47:0] end_at,
                                                        logic [31:0] bytes);
      est_pkg::req_item_type ev;
      ev.op          = op;
      ev.event_index = 4'(index);
      ev.begin_stamp = begin_at;
      ev.end_stamp   = end_at;
      ev.byte_count  = bytes;
      return ev;
   endfunction

   // Mostly short, well-formed events with random content; some long ones
   // that clip the duration, some zero-length ones and some with the stamps
   // reversed.
   function automatic est_pkg::req_item_type random_event();
      est_pkg::req_item_type ev;
      logic [47:0]           delta;
      ev.op          = 1'($urandom_range(1));
      ev.event_index = 4'($urandom_range(est_pkg::NUM_EVENTS - 1));
      ev.begin_stamp = {16'($urandom), 32'($urandom)};
      case ($urandom_range(9))
         7:       delta = 48'($urandom);
         8:       delta = {16'($urandom), 32'($urandom)};
         9:       delta = '0;
         default: delta = 48'($urandom_range(2000));
      endcase
      ev.end_stamp = ev.begin_stamp + delta;
      if ($urandom_range(9) == 0)
         ev.end_stamp = ev.begin_stamp - delta - 48'd1;
      ev.byte_count = $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(100000));
      return ev;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Straight out of reset recording is off: requests must come back as
   // all-zero results and leave the table empty.
   task automatic test_disabled_after_reset();
      issue_event(make_event(est_pkg::OP_DURATION, 0, 48'd10, 48'd90, 32'd0));
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 5, 48'd0, 48'd1000, 32'd5000));
      wait_for_idle();
      write_register(est_pkg::CSR_ENABLE, 32'd1);
   endtask

   // Duration samples: zero length, reversed stamps, clipping at the top of
   // the 32-bit range and the bounds tracking of fresh entries.
   task automatic test_duration_cases();
      issue_event(make_event(est_pkg::OP_DURATION, 0, 48'd100, 48'd100, 32'hFFFF_FFFF));
      issue_event(make_event(est_pkg::OP_DURATION, 0, 48'd100, 48'd350, 32'd0));
      issue_event(make_event(est_pkg::OP_DURATION, 0, 48'd500, 48'd20, 32'd7));
      issue_event(make_event(est_pkg::OP_DURATION, 15, 48'd0, '1, 32'd0));
      issue_event(make_event(est_pkg::OP_DURATION, 15, '1, '1, 32'd0));
      issue_event(make_event(est_pkg::OP_DURATION, 15, 48'd5, 48'd12, 32'd0));
      issue_event(make_event(est_pkg::OP_DURATION, 3, 48'h7FFF_0000_0000,
                             48'h8000_0000_0000, 32'hA5A5_A5A5));
   endtask

   // Throughput samples at the reset clock rate: a dropped zero duration,
   // a dropped reversed event, zero bytes, and a rate so high that its
   // square no longer fits. One entry mixes both kinds of sample so that
   // only the throughput ones add to the byte total.
   task automatic test_throughput_cases();
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 1, 48'd4000, 48'd4000, 32'd4096));
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 1, 48'd0, 48'd1000, 32'd4096));
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 1, 48'd0, 48'd1000, 32'd0));
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 1, 48'd41, 48'd42, 32'hFFFF_FFFF));
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 1, 48'd900, 48'd10, 32'd1234));
      issue_event(make_event(est_pkg::OP_DURATION, 2, 48'd20, 48'd30, 32'd999));
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 2, 48'd20, 48'd23, 32'd1000));
   endtask

   // Clock rate at zero, one and the maximum, then a disabled window.
   task automatic test_clock_rate_extremes();
      wait_for_idle();
      write_register(est_pkg::CSR_TICKS, 32'd0);
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 4, 48'd0, 48'd1, 32'hFFFF_FFFF));
      wait_for_idle();
      write_register(est_pkg::CSR_TICKS, 32'd1);
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 4, 48'd0, 48'd1, 32'hFFFF_FFFF));
      wait_for_idle();
      write_register(est_pkg::CSR_TICKS, 32'hFFFF_FFFF);
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 4, 48'd3, 48'd10, 32'hFFFF_FFFF));
      wait_for_idle();
      write_register(est_pkg::CSR_ENABLE, 32'd0);
      issue_event(make_event(est_pkg::OP_THROUGHPUT, 4, 48'd3, 48'd10, 32'd77));
      wait_for_idle();
      write_register(est_pkg::CSR_ENABLE, 32'd1);
   endtask

   // The largest possible rate squares past the top of 64 bits, so the sum
   // of squares of one entry sticks at all ones from its first sample on
   // while the plain sum keeps growing.
   task automatic test_sum_saturation();
      wait_for_idle();
      write_register(est_pkg::CSR_TICKS, 32'hFFFF_FFFF);
      for (int n = 0; n < SATURATE_N; n++)
         issue_event(make_event(est_pkg::OP_THROUGHPUT, 9, 48'd0, 48'd1, 32'hFFFF_FFFF));
      wait_for_idle();
   endtask

   // Random requests with the sender idling before a share of them. At item
   // drain_at, if any, the sender stops until the block has answered all.
   task automatic run_traffic(input int items, input int idle_pct, input int drain_at);
      for (int n = 0; n < items; n++) begin
         if (idle_pct > 0 && $urandom_range(99) < idle_pct)
            idle_sender($urandom_range(1, 80));
         if (n == drain_at)
            wait_for_idle();
         issue_event(random_event());
      end
      wait_for_idle();
   endtask

   // Three traffic phases, each at its own clock rate: back to back, a
   // mostly idle sender, and a lightly idle one.
   task automatic test_random_traffic();
      write_register(est_pkg::CSR_TICKS, $urandom);
      run_traffic(RANDOM_PHASE_N, 0, RANDOM_PHASE_N / 2);
      write_register(est_pkg::CSR_TICKS, est_pkg::TICKS_RESET);
      run_traffic(RANDOM_PHASE_N, 70, RANDOM_PHASE_N / 3);
      write_register(est_pkg::CSR_TICKS, $urandom_range(1, 1000000));
      run_traffic(RANDOM_PHASE_N, 8, -1);
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_item      = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      error_count   = 0;
      record_enable = 1'b0;
      tick_rate     = est_pkg::TICKS_RESET;
      for (int e = 0; e < est_pkg::NUM_EVENTS; e++)
         stat_shadow[e] = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_disabled_after_reset();
      test_duration_cases();
      test_throughput_cases();
      test_clock_rate_extremes();
      test_sum_saturation();
      test_random_traffic();

      // Give a stray late result time to show up before the verdict.
      wait_for_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_stats.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
